@@ rtl/scfp_pkg.sv @@
package scfp_pkg;

   // Byte and field widths
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 6;

   // Default buffer depth and head byte after reset
   localparam int                PAYLOAD_DEPTH_DEF = 64;
   localparam logic [BYTE_W-1:0] HEAD_RESET        = 8'h5a;

   // Parser phase
   typedef enum logic [1:0] {
      PH_HEAD,
      PH_ID,
      PH_LEN,
      PH_DATA
   } phase_type;

   // Drain sequencer state
   typedef enum logic {
      DR_IDLE,
      DR_SHOW
   } drain_state_type;

   // Request from parser to drain: frame passed its checksum and fits the buffer
   typedef struct packed {
      logic              start;
      logic              empty;
      logic [BYTE_W-1:0] id;
      logic [BYTE_W-1:0] len;
   } drain_cmd_type;

endpackage

@@ rtl/scfp_if.sv @@
interface scfp_req_if;
   import scfp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfp_rsp_if;
   import scfp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_id;
   logic [IDX_W-1:0]  payload_index;
   logic [BYTE_W-1:0] payload_byte;
   logic              is_empty;
   logic              is_last;

   modport source (output valid, output frame_id, output payload_index,
                   output payload_byte, output is_empty, output is_last,
                   input ready);
   modport sink   (input valid, input frame_id, input payload_index,
                   input payload_byte, input is_empty, input is_last,
                   output ready);
endinterface

@@ rtl/sum_checked_frame_parser.sv @@
// Channel  | Dir | Handshake       | Payload
// req_bus  | in  | valid / ready   | rx_byte
// rsp_bus  | out | valid / ready   | frame_id, payload_index, payload_byte,
//          |     |                 | is_empty, is_last
// csr      | in  | csr_wr_en       | csr_wr_data (head byte)
//
// Input bytes are taken every cycle outside a drain.
// A good frame drains at one result per cycle while the output is ready, through
// the store's registered read port; input is held off from the checksum byte
// until the last result leaves. Reset is synchronous: the parser hunts for a
// head, the head byte returns to 0x5a, and the payload store is not cleared.
module sum_checked_frame_parser #(
   parameter int PAYLOAD_DEPTH = scfp_pkg::PAYLOAD_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   scfp_req_if.sink                     req_bus,
   scfp_rsp_if.source                   rsp_bus,
   input  logic                         csr_wr_en,
   input  logic [scfp_pkg::BYTE_W-1:0]  csr_wr_data
);
   import scfp_pkg::*;

   localparam int AW  = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int WPW = $clog2(PAYLOAD_DEPTH + 1);
   localparam logic [BYTE_W-1:0] DEPTH_B = BYTE_W'(PAYLOAD_DEPTH);
   localparam logic [WPW-1:0]    DEPTH_W = WPW'(PAYLOAD_DEPTH);

   logic [BYTE_W-1:0] head_ff;
   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] id_ff, id_in;
   logic [BYTE_W-1:0] remain_ff, remain_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [WPW-1:0]    wpos_ff, wpos_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;

   logic              busy;
   logic              req_fire;
   logic [BYTE_W-1:0] c;
   logic              wr_en;
   drain_cmd_type     cmd;

   assign req_bus.ready = !busy;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign c             = req_bus.rx_byte;

   // Head byte register
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= HEAD_RESET;
      end else if (csr_wr_en) begin
         head_ff <= csr_wr_data;
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (req_fire) begin
         unique case (phase_ff)
            PH_HEAD: if (c == head_ff) phase_in = PH_ID;
            PH_ID:   phase_in = PH_LEN;
            PH_LEN:  phase_in = PH_DATA;
            PH_DATA: if (remain_ff == '0) phase_in = PH_HEAD;
            default: phase_in = PH_HEAD;
         endcase
      end
   end

   // Frame registers, store write and drain command
   always_comb begin
      id_in     = id_ff;
      remain_in = remain_ff;
      len_in    = len_ff;
      wpos_in   = wpos_ff;
      sum_in    = sum_ff;
      wr_en     = 1'b0;
      cmd       = '{start: 1'b0, empty: (len_ff == '0), id: id_ff, len: len_ff};
      if (req_fire) begin
         unique case (phase_ff)
            PH_HEAD: begin
               if (c == head_ff) begin
                  id_in     = '0;
                  len_in    = '0;
                  remain_in = '0;
                  wpos_in   = '0;
                  sum_in    = c;
               end
            end
            PH_ID: begin
               id_in  = c;
               sum_in = sum_ff + c;
            end
            PH_LEN: begin
               len_in    = c;
               remain_in = c;
               wpos_in   = '0;
               sum_in    = sum_ff + c;
            end
            PH_DATA: begin
               if (remain_ff != '0) begin
                  remain_in = remain_ff - 8'd1;
                  sum_in    = sum_ff + c;
                  // bytes beyond the buffer are counted but not kept
                  if (wpos_ff < DEPTH_W) begin
                     wr_en   = 1'b1;
                     wpos_in = wpos_ff + WPW'(1);
                  end
               end else begin
                  cmd.start = (c == sum_ff) && (len_ff <= DEPTH_B);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEAD;
         id_ff     <= '0;
         remain_ff <= '0;
         len_ff    <= '0;
         wpos_ff   <= '0;
         sum_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         id_ff     <= id_in;
         remain_ff <= remain_in;
         len_ff    <= len_in;
         wpos_ff   <= wpos_in;
         sum_ff    <= sum_in;
      end
   end

   scfp_buffer #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
      .AW            (AW)
   ) u_buffer (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .wr_en   (wr_en),
      .wr_addr (wpos_ff[AW-1:0]),
      .wr_data (c),
      .busy    (busy),
      .rsp     (rsp_bus)
   );

endmodule

@@ rtl/scfp_buffer.sv @@
module scfp_buffer #(
   parameter int PAYLOAD_DEPTH = scfp_pkg::PAYLOAD_DEPTH_DEF,
   parameter int AW            = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  scfp_pkg::drain_cmd_type      cmd,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [scfp_pkg::BYTE_W-1:0]  wr_data,
   output logic                         busy,
   scfp_rsp_if.source                   rsp
);
   import scfp_pkg::*;

   logic [BYTE_W-1:0] store_mem [PAYLOAD_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   drain_state_type   dr_state_ff, dr_state_in;
   logic [BYTE_W-1:0] id_ff, id_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic              empty_ff, empty_in;

   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              rsp_fire;
   logic              is_last;

   // Payload store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rsp_fire = rsp.valid && rsp.ready;
   assign is_last  = empty_ff || ((BYTE_W'(idx_ff) + 8'd1) == len_ff);

   // Next state
   always_comb begin
      dr_state_in = dr_state_ff;
      unique case (dr_state_ff)
         DR_IDLE: begin
            if (cmd.start) begin
               dr_state_in = DR_SHOW;
            end
         end
         DR_SHOW: begin
            if (rsp_fire && is_last) begin
               dr_state_in = DR_IDLE;
            end
         end
         default: dr_state_in = DR_IDLE;
      endcase
   end

   // Outputs, read issue and run registers
   always_comb begin
      id_in    = id_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      empty_in = empty_ff;
      rd_en    = 1'b0;
      rd_addr  = idx_ff + AW'(1);
      unique case (dr_state_ff)
         DR_IDLE: begin
            rd_addr = '0;
            if (cmd.start) begin
               id_in    = cmd.id;
               len_in   = cmd.len;
               empty_in = cmd.empty;
               idx_in   = '0;
               rd_en    = !cmd.empty;
            end
         end
         DR_SHOW: begin
            // next entry is fetched at the edge the current one leaves
            if (rsp_fire && !is_last) begin
               rd_en  = 1'b1;
               idx_in = idx_ff + AW'(1);
            end
         end
         default: ;
      endcase
   end

   assign busy              = (dr_state_ff != DR_IDLE);
   assign rsp.valid         = (dr_state_ff == DR_SHOW);
   assign rsp.frame_id      = id_ff;
   assign rsp.payload_index = IDX_W'(idx_ff);
   assign rsp.payload_byte  = empty_ff ? '0 : rd_data_ff;
   assign rsp.is_empty      = empty_ff;
   assign rsp.is_last       = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         dr_state_ff <= DR_IDLE;
      end else begin
         dr_state_ff <= dr_state_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      len_ff   <= len_in;
      idx_ff   <= idx_in;
      empty_ff <= empty_in;
   end

   // Checks
   a_cmd_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> dr_state_ff == DR_IDLE)
      else $error("drain command while a run is in progress");

   a_no_write_in_drain: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> dr_state_ff == DR_IDLE)
      else $error("store written during a drain");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !is_last |=> rsp.valid &&
         rsp.payload_index == $past(rsp.payload_index) + IDX_W'(1))
      else $error("payload index did not advance by one");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && is_last |=> !rsp.valid)
      else $error("run continued past its last transaction");

   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.is_empty |-> rsp.is_last && rsp.payload_byte == '0)
      else $error("empty frame result malformed");

endmodule
